>>> hdl/clsp_pkg.sv
// Shared types, constants and helper functions for the combined LCG / shuffle PRNG.
// Used by clsp_table and combined_lcg_shuffle_prng_top; depends on nothing else.
package clsp_pkg;

	// Shuffle table geometry
	localparam int TABLE_ENTRIES = 32;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int WARM_STEPS    = TABLE_ENTRIES + 8;
	localparam int WARM_W        = $clog2(WARM_STEPS);

	// Generator constants
	localparam logic [30:0] MOD_ONE    = 31'd2147483563;
	localparam logic [30:0] MOD_TWO    = 31'd2147483399;
	localparam logic [15:0] MUL_ONE    = 16'd40014;
	localparam logic [15:0] MUL_TWO    = 16'd40692;
	localparam logic [30:0] WRAP_TOP   = 31'd2147483562;
	localparam logic [30:0] SEED_RESET = 31'd123456789;

	// Fold constants: 2^31 - modulus
	localparam logic [7:0] FOLD_ONE = 8'd85;
	localparam logic [7:0] FOLD_TWO = 8'd249;

	// Index divisor: 1 + (MOD_ONE - 2) / TABLE_ENTRIES
	localparam longint      INDEX_DIV_L = 1 + (64'd2147483561 / TABLE_ENTRIES);
	localparam logic [31:0] INDEX_DIV   = 32'(INDEX_DIV_L);

	typedef enum logic [2:0] {
		S_IDLE,
		S_WMUL,
		S_WRED,
		S_DRD,
		S_DRED,
		S_DOUT
	} state_t;

	// Request bundle from the sequencer to the shuffle table
	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [30:0]      wr_data;
	} tbl_req_t;

	// Product of a 31-bit value with a 16-bit multiplier
	typedef logic [46:0] prod_t;

	// Reduce a product modulo 2^31 - c: hi * c + lo is below twice the modulus
	function automatic logic [30:0] fold_mod(input prod_t p, input logic [7:0] c,
			input logic [30:0] m);
		logic [31:0] sum;
		sum = {1'b0, p[30:0]} + (32'(p[46:31]) * 32'(c));
		if (sum >= {1'b0, m}) begin
			sum = sum - {1'b0, m};
		end
		return sum[30:0];
	endfunction

	// Table index = x / INDEX_DIV, saturated to the last entry
	function automatic logic [IDX_W-1:0] tbl_index(input logic [30:0] x);
		logic [IDX_W-1:0] idx;
		logic [31:0]      thr;
		idx = '0;
		for (int k = 1; k < TABLE_ENTRIES; k++) begin
			thr = 32'(k) * INDEX_DIV;
			if ({1'b0, x} >= thr) begin
				idx = IDX_W'(k);
			end
		end
		return idx;
	endfunction

endpackage

>>> hdl/clsp_table.sv
// Shuffle table: single-port-per-cycle synchronous RAM with per-entry valid bits.
// Entries never written since reset read as zero. Depends on clsp_pkg.
module clsp_table import clsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tbl_req_t    req,
	output logic [30:0] rd_data
);

	logic [30:0]              mem [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] vld_q;
	logic [30:0]              rd_data_q;
	logic                     rd_vld_q;

	// Storage and registered read
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	// Valid bits stand in for clearing the table at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				vld_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_vld_q <= vld_q[req.rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_data_q : '0;

	// Sequencer never reads and writes in one cycle, so no forwarding is needed
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.rd_en && req.wr_en))
		else $error("table read and write in the same cycle");

	// A written entry is valid from then on
	a_wr_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr_en |=> vld_q[$past(req.wr_addr)])
		else $error("written entry not marked valid");

endmodule

>>> hdl/combined_lcg_shuffle_prng_top.sv
// Top level of the combined L'Ecuyer generator with Bays-Durham shuffle.
// Holds the sequencer, both generators and the output register; uses clsp_pkg, clsp_table.
//
//  channel  | handshake            | payload
//  ---------+----------------------+--------------------------------
//  input    | in_valid / in_ready  | opcode, seed_value
//  output   | out_valid/ out_ready | random_value, generator_state
//
// A draw request steps through table read, modular fold and output/write-back.
// A reseed request adds 40 warm-up steps of the first generator,
// each a multiply state and a fold state through the first generator's multiplier.
// Reset loads the generators and marks every table entry as zero.
// A new request is taken in the output cycle of the previous one when the
// output register is free; a stalled output holds the sequencer in that cycle.
module combined_lcg_shuffle_prng_top import clsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [30:0] seed_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [30:0] random_value,
	output logic [30:0] generator_state
);

	state_t            state_q, state_d;
	logic [30:0]       g1_q, g2_q, last_q;
	logic [WARM_W-1:0] pos_q;
	prod_t             prod1_s1, prod2_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [30:0]       rand_q, gstate_q;
	logic              out_valid_q;

	tbl_req_t          tbl_req;
	logic [30:0]       tbl_rd_data;
	logic              in_acc, out_free, dout_adv;
	logic [30:0]       fold1, fold2, seed_eff;
	logic [32:0]       diff_raw;
	logic [32:0]       diff_wrap;
	logic [30:0]       new_out;

	clsp_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (tbl_req),
		.rd_data (tbl_rd_data)
	);

	// Datapath helpers
	assign fold1    = fold_mod(prod1_s1, FOLD_ONE, MOD_ONE);
	assign fold2    = fold_mod(prod2_s1, FOLD_TWO, MOD_TWO);
	assign seed_eff = (seed_value == '0) ? 31'd1 : seed_value;
	assign out_free = !out_valid_q || out_ready;
	assign dout_adv = (state_q == S_DOUT) && out_free;
	assign in_acc   = in_valid && in_ready;

	// Output entry minus second generator, wrapped into 1..WRAP_TOP
	assign diff_raw  = {2'b00, tbl_rd_data} - {2'b00, g2_q};
	assign diff_wrap = diff_raw + {2'b00, WRAP_TOP};
	assign new_out   = (diff_raw[32] || diff_raw == '0) ? diff_wrap[30:0] : diff_raw[30:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE, S_DOUT: begin
				if (state_q == S_DOUT && !out_free) begin
					state_d = S_DOUT;
				end else if (in_acc) begin
					state_d = opcode ? S_WMUL : S_DRD;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_WMUL: state_d = S_WRED;
			S_WRED: state_d = (pos_q == '0) ? S_DRD : S_WMUL;
			S_DRD:  state_d = S_DRED;
			S_DRED: state_d = S_DOUT;
			default: state_d = S_IDLE;
		endcase
	end

	// Handshake and table requests
	always_comb begin
		in_ready        = 1'b0;
		tbl_req.rd_en   = 1'b0;
		tbl_req.rd_addr = tbl_index(last_q);
		tbl_req.wr_en   = 1'b0;
		tbl_req.wr_addr = idx_s1;
		tbl_req.wr_data = g1_q;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_DOUT: begin
				in_ready      = out_free;
				tbl_req.wr_en = out_free;
			end
			S_WRED: begin
				tbl_req.wr_en   = (pos_q < WARM_W'(TABLE_ENTRIES));
				tbl_req.wr_addr = pos_q[IDX_W-1:0];
				tbl_req.wr_data = fold1;
			end
			S_DRD: tbl_req.rd_en = 1'b1;
			default: ;
		endcase
	end

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			g1_q        <= 31'd1;
			g2_q        <= SEED_RESET;
			last_q      <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Output register fills on a finished draw, empties when taken
			if (dout_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_WRED: begin
					g1_q  <= fold1;
					pos_q <= pos_q - WARM_W'(1);
					if (pos_q == '0) begin
						last_q <= fold1;
					end
				end
				S_DRED: begin
					g1_q <= fold1;
					g2_q <= fold2;
				end
				S_DOUT: begin
					if (out_free) begin
						last_q <= new_out;
					end
				end
				default: ;
			endcase
			// Reseed loads both generators and restarts the warm-up count
			if (in_acc && opcode) begin
				g1_q  <= seed_eff;
				g2_q  <= seed_eff;
				pos_q <= WARM_W'(WARM_STEPS - 1);
			end
		end
	end

	// Pipeline and output payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_WMUL || state_q == S_DRD) begin
			prod1_s1 <= prod_t'(g1_q) * prod_t'(MUL_ONE);
			prod2_s1 <= prod_t'(g2_q) * prod_t'(MUL_TWO);
		end
		if (state_q == S_DRD) begin
			idx_s1 <= tbl_req.rd_addr;
		end
		if (dout_adv) begin
			rand_q   <= new_out;
			gstate_q <= g1_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign random_value    = rand_q;
	assign generator_state = gstate_q;

	// Requests are only taken at a state boundary of the sequencer
	a_accept_state: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (state_q == S_IDLE || state_q == S_DOUT))
		else $error("request accepted while busy");

	// Folded first generator is always below its modulus
	a_g1_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DRED) |=> (g1_q < MOD_ONE))
		else $error("first generator out of range");

	// Every delivered output lies in 1..WRAP_TOP
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		dout_adv |=> (last_q != '0 && last_q <= WRAP_TOP))
		else $error("output out of range");

	// A stalled output holds the sequencer in its output cycle
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DOUT && !out_free) |=> (state_q == S_DOUT))
		else $error("sequencer left output cycle while stalled");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench for combined_lcg_shuffle_prng_top: directed table plus random draw/reseed traffic.
// Holds its own model of the two generators and the shuffle table; uses clsp_pkg.
module tb;
	import clsp_pkg::*;

	localparam logic OP_DRAW   = 1'b0;
	localparam logic OP_RESEED = 1'b1;
	localparam int   RANDOM_REQS  = 400;
	localparam int   MAX_WAIT     = 17;
	localparam int   DRAIN_CYCLES = 100;
	localparam int   STUCK_LIMIT  = 3000;
	localparam int   N_ROWS       = 18;
	localparam int   EXP_DEPTH    = 16;
	localparam longint SLOT_DIV = 1 + (longint'(MOD_ONE) - 2) / TABLE_ENTRIES;

	typedef struct packed {
		logic [30:0] rnd;
		logic [30:0] state;
	} draw_result_t;

	typedef struct packed {
		logic        op;
		logic [30:0] seed;
		logic        typed;
		logic [30:0] typed_state;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = OP_DRAW;
	logic [30:0] seed_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [30:0] random_value;
	logic [30:0] generator_state;

	// Model state
	logic [30:0] gen_one;
	logic [30:0] gen_two;
	logic [30:0] prev_out;
	logic [30:0] shuffle_tbl [TABLE_ENTRIES];

	// Expected results, in request order
	draw_result_t exp_mem [EXP_DEPTH];
	int exp_wr = 0;
	int exp_rd = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	stim_row_t stim_rows [N_ROWS];

	combined_lcg_shuffle_prng_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.seed_value(seed_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.random_value(random_value),
		.generator_state(generator_state)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// One multiplicative congruential step, done in 64 bits
	function automatic logic [30:0] lcg_step(input logic [30:0] value, input logic [15:0] mul,
			input logic [30:0] modulus);
		logic [63:0] prod;
		prod = 64'(value) * 64'(mul);
		return 31'(prod % 64'(modulus));
	endfunction

	// Advance the model by one request and return the result it should produce
	function automatic draw_result_t advance_prng(input logic op, input logic [30:0] seed);
		draw_result_t res;
		logic [30:0]  s;
		longint       slot;
		longint       diff;
		if (op == OP_RESEED) begin
			// zero seed is taken as one; out-of-range seeds are not clamped
			s = (seed == '0) ? 31'd1 : seed;
			gen_one = s;
			gen_two = s;
			for (int pos = TABLE_ENTRIES + 7; pos >= 0; pos--) begin
				gen_one = lcg_step(gen_one, MUL_ONE, MOD_ONE);
				if (pos < TABLE_ENTRIES) begin
					shuffle_tbl[pos] = gen_one;
				end
			end
			prev_out = shuffle_tbl[0];
		end
		gen_one = lcg_step(gen_one, MUL_ONE, MOD_ONE);
		gen_two = lcg_step(gen_two, MUL_TWO, MOD_TWO);
		slot = longint'(prev_out) / SLOT_DIV;
		if (slot >= TABLE_ENTRIES) begin
			slot = TABLE_ENTRIES - 1;
		end
		diff = longint'(shuffle_tbl[slot]) - longint'(gen_two);
		if (diff < 1) begin
			diff = diff + longint'(WRAP_TOP);
		end
		prev_out = diff[30:0];
		shuffle_tbl[slot] = gen_one;
		res.rnd = prev_out;
		res.state = gen_one;
		return res;
	endfunction

	// Drive one request after a random gap; returns with in_valid still high
	task automatic send_req(input logic op, input logic [30:0] seed, input logic typed,
			input logic [30:0] typed_state);
		int gap;
		draw_result_t res;
		if ($urandom_range(0, 39) == 0) begin
			src_steady = !src_steady;
		end
		gap = src_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		seed_value <= seed;
		do @(posedge clk); while (!in_ready);
		res = advance_prng(op, seed);
		if (typed) begin
			res.state = typed_state;
		end
		exp_mem[exp_wr % EXP_DEPTH] = res;
		exp_wr++;
	endtask

	// Random seed: full range half the time, else extremes or small values
	function automatic logic [30:0] pick_seed();
		case ($urandom_range(0, 5))
			0: return 31'($urandom_range(0, 3));
			1: return WRAP_TOP - 31'($urandom_range(0, 2));
			2: return MOD_ONE + 31'($urandom_range(0, 84));
			default: return 31'($urandom);
		endcase
	endfunction

	// Reset and request stream
	initial begin
		logic op;
		stim_rows[0]  = '{OP_DRAW,   31'd0,          1'b1, 31'd40014};
		stim_rows[1]  = '{OP_DRAW,   31'h7FFFFFFF,   1'b0, 31'd0};
		stim_rows[2]  = '{OP_RESEED, 31'd0,          1'b0, 31'd0};
		stim_rows[3]  = '{OP_DRAW,   31'd0,          1'b0, 31'd0};
		stim_rows[4]  = '{OP_RESEED, 31'd1,          1'b0, 31'd0};
		stim_rows[5]  = '{OP_RESEED, 31'd2147483562, 1'b0, 31'd0};
		stim_rows[6]  = '{OP_DRAW,   31'd0,          1'b0, 31'd0};
		// seed equal to the first modulus parks the first generator at zero
		stim_rows[7]  = '{OP_RESEED, 31'd2147483563, 1'b1, 31'd0};
		stim_rows[8]  = '{OP_DRAW,   31'd0,          1'b1, 31'd0};
		stim_rows[9]  = '{OP_DRAW,   31'h7FFFFFFF,   1'b1, 31'd0};
		stim_rows[10] = '{OP_RESEED, 31'h7FFFFFFF,   1'b0, 31'd0};
		stim_rows[11] = '{OP_RESEED, 31'h2AAAAAAA,   1'b0, 31'd0};
		stim_rows[12] = '{OP_RESEED, 31'h55555555,   1'b0, 31'd0};
		stim_rows[13] = '{OP_DRAW,   31'h2AAAAAAA,   1'b0, 31'd0};
		stim_rows[14] = '{OP_RESEED, SEED_RESET,     1'b0, 31'd0};
		stim_rows[15] = '{OP_DRAW,   31'd0,          1'b0, 31'd0};
		stim_rows[16] = '{OP_RESEED, 31'd2147483564, 1'b0, 31'd0};
		stim_rows[17] = '{OP_DRAW,   31'd0,          1'b0, 31'd0};

		gen_one = 31'd1;
		gen_two = SEED_RESET;
		prev_out = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			shuffle_tbl[i] = '0;
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++) begin
			send_req(stim_rows[i].op, stim_rows[i].seed, stim_rows[i].typed,
				stim_rows[i].typed_state);
		end

		// Mostly draws, with reseeds starting new sequences
		for (int i = 0; i < RANDOM_REQS; i++) begin
			if (i == RANDOM_REQS / 2) begin
				in_valid <= 1'b0;
				while (exp_wr != exp_rd) @(posedge clk);
			end
			op = ($urandom_range(0, 7) == 0) ? OP_RESEED : OP_DRAW;
			send_req(op, (op == OP_RESEED) ? pick_seed() : 31'($urandom), 1'b0, '0);
		end
		in_valid <= 1'b0;

		while (exp_wr != exp_rd) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[combined_lcg_shuffle_prng_top] OK");
		end else begin
			$display("[combined_lcg_shuffle_prng_top] ERROR");
		end
		$finish;
	end

	// Result side backpressure
	initial begin
		int stall;
		while (!arst_n) @(posedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) begin
				sink_steady = !sink_steady;
			end
			stall = sink_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each accepted result with the oldest pending draw
	always @(posedge clk) begin
		draw_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (exp_wr == exp_rd) begin
				$display("%0t: unexpected result random_value=%0d generator_state=%0d",
					$time, random_value, generator_state);
				mismatches++;
			end else begin
				want = exp_mem[exp_rd % EXP_DEPTH];
				exp_rd++;
				if (random_value !== want.rnd) begin
					$display("%0t: random_value expected %0d actual %0d",
						$time, want.rnd, random_value);
					mismatches++;
				end
				if (generator_state !== want.state) begin
					$display("%0t: generator_state expected %0d actual %0d",
						$time, want.state, generator_state);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: too long with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STUCK_LIMIT) begin
				$display("%0t: no handshake for %0d cycles", $time, idle_cycles);
				$display("[combined_lcg_shuffle_prng_top] ERROR");
				$finish;
			end
		end
	end

endmodule

>>> sim.f
hdl/clsp_pkg.sv
hdl/clsp_table.sv
hdl/combined_lcg_shuffle_prng_top.sv
tb/sv/tb.sv
